>>> sv/pil_pkg.sv
// Shared definitions for the piecewise linear interpolator.
// Table depth, derived widths, word field codes and sequencer states.
// No dependencies.
package pil_pkg;

  // Breakpoint table depth and derived widths
  localparam int MAX_POINTS = 8;
  localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Field widths of one breakpoint
  localparam int X_W     = 32;
  localparam int Y_W     = 16;
  localparam int ENTRY_W = X_W + Y_W;

  // Quotient bits: the quotient never exceeds the span of y
  localparam int QUO_W     = 16;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [DIV_CNT_W-1:0] div_cnt_t;

  // Action codes of an input word
  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_RD_FIRST,
    S_CHECK,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

endpackage

>>> sv/pil_if.sv
// Valid/ready channel interfaces of the piecewise linear interpolator.
// Input words (loads and queries) and result words. No dependencies.
interface pil_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [2:0]  point_index;
  logic [31:0] point_x;
  logic signed [15:0] point_y;
  logic [31:0] query;

  modport source (output valid, action, point_index, point_x, point_y, query,
                  input ready);
  modport sink   (input valid, action, point_index, point_x, point_y, query,
                  output ready);
endinterface

interface pil_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] value;
  logic        valid_res;

  modport source (output valid, value, valid_res, input ready);
  modport sink   (input valid, value, valid_res, output ready);
endinterface

>>> sv/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a table of up to pil_pkg::MAX_POINTS breakpoints,
// each an unsigned 32-bit x and a signed Q3.12 y, held in one small RAM (pil_ram) and
// driven through the valid/ready channels of pil_if with constants from pil_pkg. A load
// word gives no result. A query word is handled by a sequencer around the single RAM
// read port: states that fetch and test the last and first points, a scan over the
// table entries, a 16x32 multiply, a restoring subtractor for the 16-bit quotient of
// the division, then a finish state and a done state that hand the result to the
// output register. An empty table goes straight to the done state and a clamped query
// skips the scan; the done state holds the result while the previous one still waits
// in the output register. The block takes no new word while a query is in progress;
// the output register lets the next word in while a result waits.
module piecewise_linear_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  pil_in_if.sink      items,
  pil_out_if.source   results
);

  pil_pkg::state_t state, state_next;

  // Configuration and working registers
  logic [3:0]                     num_points;
  logic [31:0]                    q;
  pil_pkg::cnt_t                  n;
  pil_pkg::addr_t                 idx;
  logic [31:0]                    x_last;
  logic signed [15:0]             y_last;
  logic signed [15:0]             y_first;
  logic [31:0]                    prev_x;
  logic signed [15:0]             prev_y;
  logic [31:0]                    dx;
  logic [31:0]                    dq;
  logic [15:0]                    dy_mag;
  logic                           dy_neg;
  logic [31:0]                    rem;
  logic [15:0]                    qsh;
  pil_pkg::div_cnt_t              div_cnt;
  logic signed [15:0]             res_value;
  logic                           res_valid;
  logic                           out_valid;
  logic signed [15:0]             out_value;
  logic                           out_valid_res;

  // RAM ports
  logic                           ram_we;
  pil_pkg::addr_t                 ram_raddr;
  logic [pil_pkg::ENTRY_W-1:0]    ram_rdata;
  logic [31:0]                    rd_x;
  logic signed [15:0]             rd_y;

  // Handshake and helpers
  logic                           in_fire;
  logic                           query_fire;
  logic                           done_load;
  pil_pkg::cnt_t                  n_sat;
  pil_pkg::cnt_t                  idx_inc;
  logic                           seg_hit;
  logic signed [16:0]             dy;
  logic [47:0]                    prod;
  logic [32:0]                    trial;
  logic                           trial_ge;
  logic signed [17:0]             lerp;

  assign in_fire    = items.valid && items.ready;
  assign query_fire = in_fire && (items.action == pil_pkg::ACTION_QUERY);
  assign ram_we     = in_fire && (items.action == pil_pkg::ACTION_LOAD) &&
                      (int'(items.point_index) < pil_pkg::MAX_POINTS);
  assign done_load  = (state == pil_pkg::S_DONE) && (!out_valid || results.ready);

  assign n_sat   = (int'(num_points) > pil_pkg::MAX_POINTS) ?
                   pil_pkg::cnt_t'(pil_pkg::MAX_POINTS) : pil_pkg::cnt_t'(num_points);
  assign idx_inc = pil_pkg::cnt_t'(idx) + pil_pkg::cnt_t'(1);

  assign rd_x = ram_rdata[pil_pkg::ENTRY_W-1:pil_pkg::Y_W];
  assign rd_y = ram_rdata[pil_pkg::Y_W-1:0];

  // Segment test and slope of the bracketing segment
  assign seg_hit = (q >= prev_x) && (q < rd_x);
  assign dy      = 17'(rd_y) - 17'(prev_y);
  assign prod    = {32'd0, dy_mag} * {16'd0, dq};

  // Restoring subtractor of the division
  assign trial    = {rem, qsh[15]};
  assign trial_ge = trial >= {1'b0, dx};

  assign lerp = dy_neg ? (18'(prev_y) - $signed({2'b00, qsh}))
                       : (18'(prev_y) + $signed({2'b00, qsh}));

  // Breakpoint table: {x, y} per entry
  pil_ram #(
    .WIDTH (pil_pkg::ENTRY_W),
    .DEPTH (pil_pkg::MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pil_pkg::addr_t'(items.point_index)),
    .wdata ({items.point_x, items.point_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pil_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, read address and input ready
  always_comb begin
    state_next  = state;
    ram_raddr   = '0;
    items.ready = 1'b0;
    unique case (state)
      pil_pkg::S_IDLE: begin
        items.ready = 1'b1;
        if (query_fire) begin
          state_next = (n_sat == '0) ? pil_pkg::S_DONE : pil_pkg::S_RD_LAST;
        end
      end
      pil_pkg::S_RD_LAST: begin
        ram_raddr  = pil_pkg::addr_t'(n - pil_pkg::cnt_t'(1));
        state_next = pil_pkg::S_RD_FIRST;
      end
      pil_pkg::S_RD_FIRST: begin
        ram_raddr  = '0;
        state_next = pil_pkg::S_CHECK;
      end
      pil_pkg::S_CHECK: begin
        ram_raddr = pil_pkg::addr_t'(1);
        if (q <= rd_x || q >= x_last) begin
          state_next = pil_pkg::S_DONE;
        end else begin
          state_next = pil_pkg::S_SCAN;
        end
      end
      pil_pkg::S_SCAN: begin
        ram_raddr = pil_pkg::addr_t'(idx_inc);
        if (seg_hit) begin
          state_next = pil_pkg::S_MUL;
        end else if (idx_inc >= n) begin
          state_next = pil_pkg::S_DONE;
        end
      end
      pil_pkg::S_MUL: begin
        state_next = pil_pkg::S_DIV;
      end
      pil_pkg::S_DIV: begin
        if (div_cnt == pil_pkg::div_cnt_t'(pil_pkg::QUO_W - 1)) begin
          state_next = pil_pkg::S_FIN;
        end
      end
      pil_pkg::S_FIN: begin
        state_next = pil_pkg::S_DONE;
      end
      pil_pkg::S_DONE: begin
        if (done_load) begin
          state_next = pil_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pil_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers: config and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        num_points <= cfg_wr_data;
      end
      if (done_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      pil_pkg::S_IDLE: begin
        if (query_fire) begin
          q         <= items.query;
          n         <= n_sat;
          res_value <= '0;
          res_valid <= 1'b0;
        end
      end
      pil_pkg::S_RD_FIRST: begin
        // entry n-1 is on the read port
        x_last <= rd_x;
        y_last <= rd_y;
      end
      pil_pkg::S_CHECK: begin
        // entry 0 is on the read port
        y_first   <= rd_y;
        prev_x    <= rd_x;
        prev_y    <= rd_y;
        idx       <= pil_pkg::addr_t'(1);
        res_valid <= 1'b1;
        if (q <= rd_x) begin
          res_value <= rd_y;
        end else begin
          res_value <= y_last;
        end
      end
      pil_pkg::S_SCAN: begin
        if (seg_hit) begin
          dx     <= rd_x - prev_x;
          dq     <= q - prev_x;
          dy_neg <= dy[16];
          dy_mag <= dy[16] ? 16'(-dy) : dy[15:0];
        end else begin
          prev_x    <= rd_x;
          prev_y    <= rd_y;
          idx       <= pil_pkg::addr_t'(idx_inc);
          res_value <= y_first;
        end
      end
      pil_pkg::S_MUL: begin
        // quotient fits in 16 bits, so the top 32 bits start below dx
        rem     <= prod[47:16];
        qsh     <= prod[15:0];
        div_cnt <= '0;
      end
      pil_pkg::S_DIV: begin
        rem     <= trial_ge ? 32'(trial - {1'b0, dx}) : trial[31:0];
        qsh     <= {qsh[14:0], trial_ge};
        div_cnt <= div_cnt + pil_pkg::div_cnt_t'(1);
      end
      pil_pkg::S_FIN: begin
        res_value <= lerp[15:0];
      end
      pil_pkg::S_DONE: begin
        if (done_load) begin
          out_value     <= res_value;
          out_valid_res <= res_valid;
        end
      end
      default: begin
      end
    endcase
  end

  assign results.valid     = out_valid;
  assign results.value     = out_value;
  assign results.valid_res = out_valid_res;

`ifndef NO_ASSERTIONS
  // Scan index stays inside the table in use
  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    state == pil_pkg::S_SCAN |-> (idx != '0) && (pil_pkg::cnt_t'(idx) < n))
    else $error("scan index outside the table in use");

  // Partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == pil_pkg::S_DIV |-> rem < dx)
    else $error("division remainder not below divisor");

  // An empty-table result word carries a zero value
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.valid_res |-> results.value == 16'sd0)
    else $error("empty-table result with non-zero value");

  // No new word while a query is in progress
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != pil_pkg::S_IDLE |-> !items.ready)
    else $error("input ready during a query");
`endif

endmodule

>>> sv/pil_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sim/tb_piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// Self-checking bench for piecewise_linear_interpolator: loads breakpoint tables, queries them
// and checks every result word against an in-bench interpolation of the same table.
// Depends on pil_pkg and the pil_in_if / pil_out_if interfaces.
module tb_piecewise_linear_interpolator;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 20;
  localparam int PHASE_WORDS    = 100;

  typedef struct {
    logic               action;
    logic [2:0]         point_index;
    logic [31:0]        point_x;
    logic signed [15:0] point_y;
    logic [31:0]        query;
  } word_t;

  typedef struct {
    logic signed [15:0] value;
    logic               valid_res;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // bench-side copies of the block inputs, known from time zero
  logic               cfg_en      = 1'b0;
  logic [3:0]         cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_action   = pil_pkg::ACTION_LOAD;
  logic [2:0]         in_index    = '0;
  logic [31:0]        in_x        = '0;
  logic signed [15:0] in_y        = '0;
  logic [31:0]        in_query    = '0;
  logic               out_ready   = 1'b0;

  pil_in_if  items_if ();
  pil_out_if results_if ();

  assign items_if.valid       = in_valid;
  assign items_if.action      = in_action;
  assign items_if.point_index = in_index;
  assign items_if.point_x     = in_x;
  assign items_if.point_y     = in_y;
  assign items_if.query       = in_query;
  assign results_if.ready     = out_ready;

  piecewise_linear_interpolator u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_en),
    .cfg_wr_data (cfg_data),
    .items       (items_if),
    .results     (results_if)
  );

  always #5 clk = ~clk;

  // words waiting to be sent, and results the table says must come back
  word_t   pending_words[$];
  result_t expected_results[$];

  // predicted table and point count
  logic [31:0]        table_x[pil_pkg::MAX_POINTS];
  logic signed [15:0] table_y[pil_pkg::MAX_POINTS];
  logic [3:0]         points_in_use = '0;

  // stimulus-side view of the x values, for aiming queries at segments
  logic [31:0] planned_x[pil_pkg::MAX_POINTS];

  int errors      = 0;
  int gap_max     = 0;
  int stall_max   = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  int points_plan[6] = '{15, 1, 2, 0, 8, 9};

  // interpolate over the predicted table, truncating the quotient toward zero
  function automatic result_t interpolate_expected(logic [31:0] q);
    result_t             r;
    int                  n;
    bit                  found;
    longint              v;
    longint              dy;
    longint unsigned     mag;
    longint unsigned     quo;
    logic [31:0]         dx;
    logic [31:0]         dq;
    n = (int'(points_in_use) > pil_pkg::MAX_POINTS) ? pil_pkg::MAX_POINTS
                                                     : int'(points_in_use);
    if (n == 0) begin
      r.value     = '0;
      r.valid_res = 1'b0;
      return r;
    end
    if (q <= table_x[0]) begin
      v = table_y[0];
    end else if (q >= table_x[n-1]) begin
      v = table_y[n-1];
    end else begin
      // no bracketing segment (table not ascending) falls back to the first y
      v     = table_y[0];
      found = 1'b0;
      for (int i = 0; i < n - 1; i++) begin
        if (!found && q >= table_x[i] && q < table_x[i+1]) begin
          found = 1'b1;
          dx    = table_x[i+1] - table_x[i];
          dq    = q - table_x[i];
          dy    = longint'(table_y[i+1]) - longint'(table_y[i]);
          mag   = longint'(dy < 0 ? -dy : dy) * {32'd0, dq};
          if (dx == 32'd0) begin
            v = table_y[i];
          end else begin
            quo = mag / {32'd0, dx};
            v   = (dy < 0) ? longint'(table_y[i]) - longint'(quo)
                           : longint'(table_y[i]) + longint'(quo);
          end
        end
      end
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    r.value     = v[15:0];
    r.valid_res = 1'b1;
    return r;
  endfunction

  // driver: presents queued words, updates the prediction on each accepted word
  always @(posedge clk) begin
    logic  nv;
    word_t w;
    nv = in_valid;
    if (rst) begin
      nv       = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && items_if.ready) begin
        if (in_action == pil_pkg::ACTION_LOAD) begin
          table_x[in_index] = in_x;
          table_y[in_index] = in_y;
        end else begin
          expected_results.insert(expected_results.size(), interpolate_expected(in_query));
        end
        nv       = 1'b0;
        gap_left = $urandom_range(0, gap_max);
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          w         = pending_words.pop_front();
          in_action <= w.action;
          in_index  <= w.point_index;
          in_x      <= w.point_x;
          in_y      <= w.point_y;
          in_query  <= w.query;
          nv        = 1'b1;
        end
      end
    end
    in_valid <= nv;
  end

  // monitor: back-pressure per result word, compare against the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (results_if.valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: value %0d valid_res %0b",
                   $time, results_if.value, results_if.valid_res);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (results_if.value !== e.value || results_if.valid_res !== e.valid_res) begin
            $display("%0t: mismatch: expected value %0d valid_res %0b, got value %0d valid_res %0b",
                     $time, e.value, e.valid_res, results_if.value, results_if.valid_res);
            errors++;
          end
        end
        stall_left = $urandom_range(0, stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && items_if.ready) || (results_if.valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic queue_load(input int slot, input logic [31:0] x, input logic [15:0] y);
    word_t w;
    w.action      = pil_pkg::ACTION_LOAD;
    w.point_index = slot[2:0];
    w.point_x     = x;
    w.point_y     = y;
    w.query       = $urandom;   // ignored by a load
    pending_words.insert(pending_words.size(), w);
    planned_x[slot] = x;
  endtask

  task automatic queue_query(input logic [31:0] q);
    word_t w;
    w.action      = pil_pkg::ACTION_QUERY;
    w.point_index = 3'($urandom_range(0, 7));   // ignored by a query
    w.point_x     = $urandom;
    w.point_y     = 16'($urandom);
    w.query       = q;
    pending_words.insert(pending_words.size(), w);
  endtask

  // wait until every word is sent and answered, then let the sequencer settle
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_points(input logic [3:0] n);
    @(posedge clk);
    cfg_en   <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_en   <= 1'b0;
    points_in_use = n;
  endtask

  // random phase: mostly a fresh table then queries aimed at its segments
  task automatic random_phase(input int count);
    int          n;
    int          seg;
    int          k;
    int          j;
    logic [31:0] xs[pil_pkg::MAX_POINTS];
    logic [31:0] mask;
    logic [31:0] t;
    logic [31:0] span;
    logic [31:0] q;
    logic [15:0] y;
    n = (int'(points_in_use) > pil_pkg::MAX_POINTS) ? pil_pkg::MAX_POINTS
                                                     : int'(points_in_use);
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 2))
        0:       mask = 32'h0000_003F;
        1:       mask = 32'h000F_FFFF;
        default: mask = 32'hFFFF_FFFF;
      endcase
      for (int i = 0; i < pil_pkg::MAX_POINTS; i++) xs[i] = $urandom & mask;
      // most tables ascend; the rest are left in draw order
      if ($urandom_range(0, 4) != 0) begin
        for (int i = 1; i < pil_pkg::MAX_POINTS; i++) begin
          t = xs[i];
          j = i - 1;
          while (j >= 0 && xs[j] > t) begin
            xs[j+1] = xs[j];
            j--;
          end
          xs[j+1] = t;
        end
      end
      for (int i = 0; i < pil_pkg::MAX_POINTS; i++) begin
        case ($urandom_range(0, 5))
          0:       y = 16'h8000;
          1:       y = 16'h7FFF;
          default: y = 16'($urandom);
        endcase
        queue_load(i, xs[i], y);
      end
      count -= pil_pkg::MAX_POINTS;
    end
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        // stray load into a live table
        queue_load($urandom_range(0, pil_pkg::MAX_POINTS - 1), $urandom, 16'($urandom));
      end else begin
        case ($urandom_range(0, 7))
          0:       q = $urandom;
          1:       q = (n > 0) ? planned_x[$urandom_range(0, n - 1)] : $urandom;
          2:       q = planned_x[0] - $urandom_range(0, 3);
          3:       q = (n > 0) ? planned_x[n-1] + $urandom_range(0, 3) : $urandom;
          default: begin
            if (n >= 2) begin
              seg  = $urandom_range(0, n - 2);
              span = planned_x[seg+1] - planned_x[seg];
              q    = planned_x[seg] + ((span == 32'd0) ? 32'd0 : $urandom % span);
            end else begin
              q = $urandom;
            end
          end
        endcase
        queue_query(q);
      end
    end
  endtask

  // stimulus sequence
  initial begin
    logic [31:0] dir_x[pil_pkg::MAX_POINTS];
    logic [15:0] dir_y[pil_pkg::MAX_POINTS];
    dir_x = '{32'd0, 32'd100, 32'd1000, 32'd70000, 32'h0010_0000, 32'h1000_0000,
              32'h8000_0000, 32'hFFFF_FFFF};
    dir_y = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd1234, 16'hB1E0,
              16'h7FFF, 16'h8000};
    gap_max   = 0;
    stall_max = 3;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table answers invalid; then fill every slot
    queue_query(32'd0);
    queue_query(32'hFFFF_FFFF);
    for (int i = 0; i < pil_pkg::MAX_POINTS; i++) queue_load(i, dir_x[i], dir_y[i]);
    drain();
    write_points(4'd8);

    // clamps at both ends, exact breakpoints, steep and wide segments
    queue_query(32'd0);
    queue_query(32'd50);
    queue_query(32'd99);
    queue_query(32'd100);
    queue_query(32'd550);
    queue_query(32'd70001);
    queue_query(32'h7FFF_FFFF);
    queue_query(32'hFFFF_FFFE);
    queue_query(32'hFFFF_FFFF);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_points((p < 6) ? 4'(points_plan[p]) : 4'($urandom_range(0, 15)));
      gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 3;
      stall_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      random_phase(PHASE_WORDS);
      drain();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
